// ===== hdl/ini_text_tokenizer_assert.svh =====
// Assertion macros shared by the INI text tokenizer RTL.
// Depends on nothing; the including module supplies clock, reset and signals.
`ifndef INI_TEXT_TOKENIZER_ASSERT_SVH
`define INI_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/itt_pkg.sv =====
// Package of the INI text tokenizer: codes, characters, enums and structs.
// Used by the controller, the datapath and the top level.
`default_nettype none

package itt_pkg;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    M_START   = 3'd0,
    M_COMMENT = 3'd1,
    M_SECTION = 3'd2,
    M_KEY     = 3'd3,
    M_VSTART  = 3'd4,
    M_VALUE   = 3'd5,
    M_QUOTE   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    K_SECT  = 3'd0,
    K_CLOSE = 3'd1,
    K_KEY   = 3'd2,
    K_VAL   = 3'd3,
    K_PAIR  = 3'd4,
    K_ACC   = 3'd5,
    K_REJ   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    P_NONE,
    P_ONE,
    P_TWO,
    P_REL
  } plan_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_FIRST,
    EM_PEND,
    EM_HELD
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PEND,
    ST_HELD
  } state_t;

  typedef struct packed {
    logic  take;
    logic  rd;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  slot_free;
    plan_t plan;
    logic  idx_last;
  } dp_stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/itt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used by the tokenizer datapath for its pending blank store.
`default_nettype none

module itt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/itt_ctrl.sv =====
// Controller state machine of the INI text tokenizer.
// Depends on itt_pkg; drives the datapath through command and status structs.
`default_nettype none

module itt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire itt_pkg::dp_stat_t stat,
  output itt_pkg::ctrl_cmd_t    cmd
);

  itt_pkg::state_t state_r;
  itt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itt_pkg::ST_IDLE: begin
        if (in_valid && stat.slot_free) begin
          if (stat.plan == itt_pkg::P_REL) begin
            state_nxt = itt_pkg::ST_READ;
          end else if (stat.plan == itt_pkg::P_TWO) begin
            state_nxt = itt_pkg::ST_HELD;
          end
        end
      end
      itt_pkg::ST_READ: begin
        state_nxt = itt_pkg::ST_PEND;
      end
      itt_pkg::ST_PEND: begin
        if (stat.slot_free) begin
          state_nxt = stat.idx_last ? itt_pkg::ST_HELD : itt_pkg::ST_READ;
        end
      end
      itt_pkg::ST_HELD: begin
        if (stat.slot_free) begin
          state_nxt = itt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.take = 1'b0;
    cmd.rd   = 1'b0;
    cmd.emit = itt_pkg::EM_NONE;
    unique case (state_r)
      itt_pkg::ST_IDLE: begin
        in_ready = stat.slot_free;
        cmd.take = in_valid && stat.slot_free;
        if (cmd.take && (stat.plan == itt_pkg::P_ONE || stat.plan == itt_pkg::P_TWO)) begin
          cmd.emit = itt_pkg::EM_FIRST;
        end
      end
      itt_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      itt_pkg::ST_PEND: begin
        if (stat.slot_free) begin
          cmd.emit = itt_pkg::EM_PEND;
        end
      end
      itt_pkg::ST_HELD: begin
        if (stat.slot_free) begin
          cmd.emit = itt_pkg::EM_HELD;
        end
      end
      default: begin
        cmd.emit = itt_pkg::EM_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/itt_dp.sv =====
// Datapath of the INI text tokenizer: parse state, byte decode, pending store, output register.
// Depends on itt_pkg and itt_ram; steered by itt_ctrl through command and status structs.
`default_nettype none

module itt_dp #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_end,
  input  wire itt_pkg::ctrl_cmd_t cmd,
  output itt_pkg::dp_stat_t       stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [2:0]              out_kind,
  output logic [7:0]              out_byte,
  output logic                    out_last
);

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  itt_pkg::mode_t  mode_r, mode_nxt;
  logic            seen_r, seen_nxt;
  logic            failed_r, failed_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r;
  itt_pkg::kind_t  held_kind_r, held_kind_nxt;
  logic [7:0]      held_byte_r, held_byte_nxt;
  itt_pkg::kind_t  first_kind;
  logic [7:0]      first_byte;
  itt_pkg::plan_t  plan;
  logic            hold_we;
  logic            hold_full;
  logic            blank;
  logic [7:0]      rd_data;
  logic            out_valid_r;
  itt_pkg::kind_t  out_kind_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  assign blank     = itt_pkg::is_blank(in_byte);
  assign hold_full = (count_r >= CW'(PENDING_DEPTH));

  always_comb begin
    mode_nxt      = mode_r;
    seen_nxt      = seen_r;
    failed_nxt    = failed_r;
    count_nxt     = count_r;
    held_kind_nxt = held_kind_r;
    held_byte_nxt = in_byte;
    first_kind    = itt_pkg::K_KEY;
    first_byte    = in_byte;
    plan          = itt_pkg::P_NONE;
    hold_we       = 1'b0;
    if (in_end) begin
      failed_nxt = failed_r || (mode_r == itt_pkg::M_QUOTE);
      plan       = itt_pkg::P_ONE;
      if (!failed_nxt) begin
        if (mode_r == itt_pkg::M_SECTION || mode_r == itt_pkg::M_KEY) begin
          failed_nxt = 1'b1;
        end else if (mode_r == itt_pkg::M_VSTART || mode_r == itt_pkg::M_VALUE) begin
          plan = itt_pkg::P_TWO;
        end
      end
      held_kind_nxt = failed_nxt ? itt_pkg::K_REJ : itt_pkg::K_ACC;
      held_byte_nxt = 8'h00;
      if (plan == itt_pkg::P_TWO) begin
        first_kind = itt_pkg::K_PAIR;
      end else begin
        first_kind = held_kind_nxt;
      end
      first_byte = 8'h00;
      mode_nxt   = itt_pkg::M_START;
      seen_nxt   = 1'b0;
      failed_nxt = 1'b0;
      count_nxt  = '0;
    end else if (!failed_r) begin
      unique case (mode_r)
        itt_pkg::M_START: begin
          if (!blank) begin
            if (in_byte == itt_pkg::CH_SEMI) begin
              mode_nxt = itt_pkg::M_COMMENT;
            end else if (in_byte == itt_pkg::CH_LBRK) begin
              mode_nxt = itt_pkg::M_SECTION;
            end else if (in_byte == itt_pkg::CH_EQ || in_byte == itt_pkg::CH_QUOTE || !seen_r) begin
              failed_nxt = 1'b1;
              count_nxt  = '0;
            end else begin
              plan       = itt_pkg::P_ONE;
              first_kind = itt_pkg::K_KEY;
              mode_nxt   = itt_pkg::M_KEY;
            end
          end
        end
        itt_pkg::M_COMMENT: begin
          if (in_byte == itt_pkg::CH_NL) begin
            mode_nxt = itt_pkg::M_START;
          end
        end
        itt_pkg::M_SECTION: begin
          if (in_byte == itt_pkg::CH_SEMI || in_byte == itt_pkg::CH_NL ||
              in_byte == itt_pkg::CH_LBRK) begin
            failed_nxt = 1'b1;
            count_nxt  = '0;
          end else if (in_byte == itt_pkg::CH_RBRK) begin
            plan       = itt_pkg::P_ONE;
            first_kind = itt_pkg::K_CLOSE;
            first_byte = 8'h00;
            seen_nxt   = 1'b1;
            mode_nxt   = itt_pkg::M_START;
          end else begin
            plan       = itt_pkg::P_ONE;
            first_kind = itt_pkg::K_SECT;
          end
        end
        itt_pkg::M_KEY: begin
          if (in_byte == itt_pkg::CH_SEMI || in_byte == itt_pkg::CH_NL ||
              in_byte == itt_pkg::CH_LBRK || in_byte == itt_pkg::CH_RBRK ||
              in_byte == itt_pkg::CH_QUOTE) begin
            failed_nxt = 1'b1;
            count_nxt  = '0;
          end else if (in_byte == itt_pkg::CH_EQ) begin
            count_nxt = '0;
            mode_nxt  = itt_pkg::M_VSTART;
          end else if (blank) begin
            if (hold_full) begin
              failed_nxt = 1'b1;
              count_nxt  = '0;
            end else begin
              hold_we   = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            first_kind    = itt_pkg::K_KEY;
            held_kind_nxt = itt_pkg::K_KEY;
            plan          = (count_r != '0) ? itt_pkg::P_REL : itt_pkg::P_ONE;
          end
        end
        itt_pkg::M_VSTART: begin
          if (in_byte == itt_pkg::CH_SEMI || in_byte == itt_pkg::CH_NL) begin
            plan       = itt_pkg::P_ONE;
            first_kind = itt_pkg::K_PAIR;
            first_byte = 8'h00;
            count_nxt  = '0;
            mode_nxt   = (in_byte == itt_pkg::CH_SEMI) ? itt_pkg::M_COMMENT : itt_pkg::M_START;
          end else if (!blank) begin
            plan       = itt_pkg::P_ONE;
            first_kind = itt_pkg::K_VAL;
            mode_nxt   = (in_byte == itt_pkg::CH_QUOTE) ? itt_pkg::M_QUOTE : itt_pkg::M_VALUE;
          end
        end
        itt_pkg::M_VALUE: begin
          if (in_byte == itt_pkg::CH_SEMI || in_byte == itt_pkg::CH_NL) begin
            plan       = itt_pkg::P_ONE;
            first_kind = itt_pkg::K_PAIR;
            first_byte = 8'h00;
            count_nxt  = '0;
            mode_nxt   = (in_byte == itt_pkg::CH_SEMI) ? itt_pkg::M_COMMENT : itt_pkg::M_START;
          end else if (blank) begin
            if (hold_full) begin
              failed_nxt = 1'b1;
              count_nxt  = '0;
            end else begin
              hold_we   = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            first_kind    = itt_pkg::K_VAL;
            held_kind_nxt = itt_pkg::K_VAL;
            plan          = (count_r != '0) ? itt_pkg::P_REL : itt_pkg::P_ONE;
            if (in_byte == itt_pkg::CH_QUOTE) begin
              mode_nxt = itt_pkg::M_QUOTE;
            end
          end
        end
        itt_pkg::M_QUOTE: begin
          plan       = itt_pkg::P_ONE;
          first_kind = itt_pkg::K_VAL;
          if (in_byte == itt_pkg::CH_QUOTE) begin
            mode_nxt = itt_pkg::M_VALUE;
          end
        end
        default: begin
          failed_nxt = 1'b1;
          count_nxt  = '0;
        end
      endcase
    end
  end

  itt_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH)
  ) u_pend (
    .clk     (clk),
    .wr_en   (cmd.take && hold_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= itt_pkg::M_START;
      seen_r   <= 1'b0;
      failed_r <= 1'b0;
      count_r  <= '0;
      idx_r    <= '0;
    end else if (cmd.take) begin
      mode_r   <= mode_nxt;
      seen_r   <= seen_nxt;
      failed_r <= failed_nxt;
      count_r  <= count_nxt;
    end else if (cmd.emit == itt_pkg::EM_PEND) begin
      if (stat.idx_last) begin
        idx_r   <= '0;
        count_r <= '0;
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held_kind_r <= held_kind_nxt;
      held_byte_r <= held_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != itt_pkg::EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      itt_pkg::EM_FIRST: begin
        out_kind_r <= first_kind;
        out_byte_r <= first_byte;
        out_last_r <= (plan == itt_pkg::P_ONE);
      end
      itt_pkg::EM_PEND: begin
        out_kind_r <= held_kind_r;
        out_byte_r <= rd_data;
        out_last_r <= 1'b0;
      end
      itt_pkg::EM_HELD: begin
        out_kind_r <= held_kind_r;
        out_byte_r <= held_byte_r;
        out_last_r <= 1'b1;
      end
      itt_pkg::EM_NONE: begin
        out_kind_r <= out_kind_r;
      end
      default: begin
        out_kind_r <= out_kind_r;
      end
    endcase
  end

  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.plan      = plan;
  assign stat.idx_last  = ((CW'(idx_r) + CW'(1)) == count_r);

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/ini_text_tokenizer.sv =====
// Top level of the INI text tokenizer: joins controller and datapath, holds the assertions.
// Depends on itt_pkg, itt_ctrl, itt_dp, itt_ram and ini_text_tokenizer_assert.svh.
//
// The input stream carries one byte of INI text per request in in_tdata; a request with
// in_tlast high marks the end of the text, its byte is ignored and it acts as a final
// newline followed by an accepted or rejected verdict. The output stream carries one token
// per request: the kind in out_tuser, the byte in out_tdata and, in out_tlast, a flag on
// the final token caused by an input request.
// A request that yields one token shows it in the output register in the cycle after it
// is accepted; the next byte is taken in that cycle if out_tready is high, so plain text
// moves at one byte per cycle while the receiver keeps up. A byte that releases held
// trailing blanks reads each from the pending store (a registered read) and emits it, then
// its own byte; an end request closing a pair emits the pair close, then the verdict. Up to
// PENDING_DEPTH blanks are held. When the receiver stalls, the output register keeps its
// token and in_tready stays low until the token is taken. Synchronous reset empties the
// output register and returns the parser to a line start with no section seen and no error.
`default_nettype none
`include "ini_text_tokenizer_assert.svh"

module ini_text_tokenizer #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] token_byte
  output logic [2:0]      out_tuser,  // [2:0] token_kind
  output logic            out_tlast
);

  itt_pkg::ctrl_cmd_t cmd;
  itt_pkg::dp_stat_t  stat;

  itt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itt_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  `ITT_ASSERT_NOW(a_take_free, clk, rst_n, in_tvalid && in_tready,
    !out_tvalid || out_tready, "Input taken while the output register is still full.")
  `ITT_ASSERT_NOW(a_verdict_last, clk, rst_n,
    out_tvalid && (out_tuser == itt_pkg::K_ACC || out_tuser == itt_pkg::K_REJ),
    out_tlast, "Verdict token is not the last of its run.")
  `ITT_ASSERT_NOW(a_zero_byte, clk, rst_n,
    out_tvalid && (out_tuser == itt_pkg::K_CLOSE || out_tuser == itt_pkg::K_PAIR ||
    out_tuser == itt_pkg::K_ACC || out_tuser == itt_pkg::K_REJ),
    out_tdata == 8'h00, "Token without a byte carries a nonzero byte.")
  `ITT_ASSERT_NEXT(a_end_verdict, clk, rst_n, in_tvalid && in_tready && in_tlast,
    out_tvalid && (out_tuser == itt_pkg::K_ACC || out_tuser == itt_pkg::K_REJ ||
    out_tuser == itt_pkg::K_PAIR), "End of text does not yield a pair close or a verdict.")

endmodule

`default_nettype wire
